[rtl/core/sps_pkg.sv]
// shared constants, types and state codes of the sorted pair sum search
package sps_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef enum logic {
      ST_LOAD,
      ST_SCAN
   } sps_state_type;

   // start of a scan, handed from the load side to the scan engine
   typedef struct packed {
      logic                     start;
      logic [CNT_W-1:0]         count;
      logic signed [DATA_W-1:0] target;
   } sps_scan_ctl_type;

   // outcome of a scan
   typedef struct packed {
      logic                     done;
      logic                     found;
      logic signed [DATA_W-1:0] smaller;
      logic signed [DATA_W-1:0] larger;
   } sps_scan_sts_type;

endpackage

[rtl/core/sps_if.sv]
// valid/ready channels for list items and search results
interface sps_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [sps_pkg::DATA_W-1:0] value;
   logic signed [sps_pkg::DATA_W-1:0] target_sum;
   logic                             is_last;

   modport source (output valid, output value, output target_sum, output is_last,
                   input ready);
   modport sink   (input valid, input value, input target_sum, input is_last,
                   output ready);
endinterface

interface sps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic signed [sps_pkg::DATA_W-1:0] smaller_value;
   logic signed [sps_pkg::DATA_W-1:0] larger_value;
   logic                             overflowed;

   modport source (output valid, output found, output smaller_value,
                   output larger_value, output overflowed, input ready);
   modport sink   (input valid, input found, input smaller_value,
                   input larger_value, input overflowed, output ready);
endinterface

[rtl/core/sorted_pair_sum_search_top.sv]
// top level of the sorted pair sum search: list loading, scan control, result register
//
// Takes a nondecreasing list of signed 32-bit values, one per req transfer, into an
// on-chip store of sps_pkg::MAX_ITEMS entries; values past that capacity are dropped
// and the result reports overflowed. The transfer marked is_last also carries the
// target sum. After the last item the block stops taking items and runs a
// two-pointer scan: each cycle one pair is read from two copies of the store (one
// per index) and its 33-bit sum compared with the target, moving the high index
// down or the low index up. The scan opens with a priming read and then runs
// compare steps until a pair matches or the indices meet, all through the single
// compare-and-step loop over the store's read ports. Exactly one rsp transfer
// follows each last item, with found = 0 and zero values when no pair matches or
// fewer than two values were stored. The result sits in an output register, so
// loading of the next list goes on while it waits to be taken; a scan that finishes
// while the register is still full stalls until it drains. There is no clearing
// pass: values at unwritten entries never reach a compare.
module sorted_pair_sum_search_top (
   input  logic       clock,
   input  logic       reset,
   sps_req_if.sink    req,
   sps_rsp_if.source  rsp
);

   // fsm
   sps_pkg::sps_state_type state_ff, state_in;

   // load side
   logic [sps_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      ovf_ff, ovf_in;
   logic                      req_xfer;
   logic                      room;
   logic                      wr_en;
   logic [sps_pkg::CNT_W-1:0] cnt_stored;

   // scan engine link
   sps_pkg::sps_scan_ctl_type scan_ctl;
   sps_pkg::sps_scan_sts_type scan_sts;
   logic [sps_pkg::ADDR_W-1:0] lo_addr;
   logic [sps_pkg::ADDR_W-1:0] hi_addr;
   logic [sps_pkg::DATA_W-1:0] lo_data;
   logic [sps_pkg::DATA_W-1:0] hi_data;
   logic                       rsp_free;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff;
   logic signed [sps_pkg::DATA_W-1:0] smaller_ff;
   logic signed [sps_pkg::DATA_W-1:0] larger_ff;
   logic                              ovfd_ff;

   // items are taken only while loading
   always_comb begin
      req.ready = 1'b0;
      unique case (state_ff)
         sps_pkg::ST_LOAD: req.ready = 1'b1;
         sps_pkg::ST_SCAN: req.ready = 1'b0;
         default:          req.ready = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sps_pkg::ST_LOAD: begin
            if (req_xfer && req.is_last) begin
               state_in = sps_pkg::ST_SCAN;
            end
         end
         sps_pkg::ST_SCAN: begin
            if (scan_sts.done) begin
               state_in = sps_pkg::ST_LOAD;
            end
         end
         default: state_in = sps_pkg::ST_LOAD;
      endcase
   end

   assign req_xfer = req.valid && req.ready;
   assign room     = cnt_ff < sps_pkg::CNT_W'(sps_pkg::MAX_ITEMS);
   assign wr_en    = req_xfer && room;

   // count including the item in this transfer when there is room, handed to the scan on the last one
   assign cnt_stored = room ? cnt_ff + sps_pkg::CNT_W'(1) : cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (req_xfer) begin
         cnt_in = req.is_last ? '0 : cnt_stored;
         if (!room) begin
            ovf_in = 1'b1;
         end
      end else if (scan_sts.done) begin
         // list finished: overflow flag moves into the result
         ovf_in = 1'b0;
      end
   end

   always_comb begin
      scan_ctl.start  = req_xfer && req.is_last;
      scan_ctl.count  = cnt_stored;
      scan_ctl.target = req.target_sum;
   end

   // two copies of the store so both indices are read in the same cycle
   sps_ram #(
      .WIDTH (sps_pkg::DATA_W),
      .DEPTH (sps_pkg::MAX_ITEMS)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[sps_pkg::ADDR_W-1:0]),
      .wr_data (req.value),
      .rd_addr (lo_addr),
      .rd_data (lo_data)
   );

   sps_ram #(
      .WIDTH (sps_pkg::DATA_W),
      .DEPTH (sps_pkg::MAX_ITEMS)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[sps_pkg::ADDR_W-1:0]),
      .wr_data (req.value),
      .rd_addr (hi_addr),
      .rd_data (hi_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   sps_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .hold    (!rsp_free),
      .lo_data ($signed(lo_data)),
      .hi_data ($signed(hi_data)),
      .lo_addr (lo_addr),
      .hi_addr (hi_addr),
      .sts     (scan_sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (scan_sts.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sps_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the result register, loaded when a scan completes
   always_ff @(posedge clock) begin
      if (scan_sts.done) begin
         found_ff   <= scan_sts.found;
         smaller_ff <= scan_sts.smaller;
         larger_ff  <= scan_sts.larger;
         ovfd_ff    <= ovf_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.found         = found_ff;
   assign rsp.smaller_value = smaller_ff;
   assign rsp.larger_value  = larger_ff;
   assign rsp.overflowed    = ovfd_ff;

endmodule

[rtl/core/sps_ram.sv]
// generic single write port, single read port ram with registered read
module sps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sps_scan.sv]
// two-pointer scan engine: low and high index, one compare step per cycle, the final step held while hold is set
module sps_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  sps_pkg::sps_scan_ctl_type        ctl,
   input  logic                             hold,
   input  logic signed [sps_pkg::DATA_W-1:0] lo_data,
   input  logic signed [sps_pkg::DATA_W-1:0] hi_data,
   output logic [sps_pkg::ADDR_W-1:0]        lo_addr,
   output logic [sps_pkg::ADDR_W-1:0]        hi_addr,
   output sps_pkg::sps_scan_sts_type         sts
);

   logic                              active_ff, active_in;
   logic                              prime_ff, prime_in;
   logic [sps_pkg::ADDR_W-1:0]        lo_ff, lo_in;
   logic [sps_pkg::ADDR_W-1:0]        hi_ff, hi_in;
   logic signed [sps_pkg::DATA_W-1:0] tgt_ff, tgt_in;

   logic signed [sps_pkg::DATA_W:0]   sum_w;
   logic signed [sps_pkg::DATA_W:0]   tgt_w;
   logic [sps_pkg::CNT_W-1:0]         cnt_m1;
   logic                              decide;
   logic                              exhausted;
   logic                              hit;
   logic                              finish;

   assign sum_w = {lo_data[sps_pkg::DATA_W-1], lo_data}
                + {hi_data[sps_pkg::DATA_W-1], hi_data};
   assign tgt_w = {tgt_ff[sps_pkg::DATA_W-1], tgt_ff};
   assign cnt_m1 = ctl.count - sps_pkg::CNT_W'(1);

   // ram data matches lo_ff/hi_ff except in the priming cycle
   assign decide    = active_ff && !prime_ff;
   assign exhausted = lo_ff >= hi_ff;
   assign hit       = sum_w == tgt_w;
   assign finish    = decide && (exhausted || hit);

   always_comb begin
      active_in = active_ff;
      prime_in  = 1'b0;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      tgt_in    = tgt_ff;
      if (ctl.start) begin
         active_in = 1'b1;
         prime_in  = 1'b1;
         tgt_in    = ctl.target;
         lo_in     = '0;
         hi_in     = (ctl.count >= sps_pkg::CNT_W'(2)) ? cnt_m1[sps_pkg::ADDR_W-1:0] : '0;
      end else if (finish) begin
         if (!hold) begin
            active_in = 1'b0;
         end
      end else if (decide) begin
         if (sum_w > tgt_w) begin
            hi_in = hi_ff - sps_pkg::ADDR_W'(1);
         end else begin
            lo_in = lo_ff + sps_pkg::ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         prime_ff  <= 1'b0;
         lo_ff     <= '0;
         hi_ff     <= '0;
         tgt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         prime_ff  <= prime_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         tgt_ff    <= tgt_in;
      end
   end

   // read ahead at the next indices so data lines up with the registers
   assign lo_addr = lo_in;
   assign hi_addr = hi_in;

   always_comb begin
      sts.done    = finish && !hold;
      sts.found   = hit && !exhausted;
      sts.smaller = (hit && !exhausted) ? lo_data : '0;
      sts.larger  = (hit && !exhausted) ? hi_data : '0;
   end

endmodule
